### rtl/pte_pkg.sv
// package: payload structs, entry layout, status codes and fixed point helpers
`default_nettype none
package pte_pkg;

  localparam int MaxEntries = 32;
  localparam int SlotBits = 5;
  localparam int CountBits = 6;

  typedef enum logic [1:0] {
    OP_LAUNCH = 2'd0,
    OP_REMOVE = 2'd1,
    OP_TICK   = 2'd2,
    OP_READ   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2,
    ST_REMOVED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_MODE    = 2'd0,
    REG_GRAVITY = 2'd1,
    REG_BOX_MIN = 2'd2,
    REG_BOX_MAX = 2'd3
  } cfg_reg_t;

  localparam logic [1:0] BndBounce = 2'd1;
  localparam logic [1:0] BndDelete = 2'd2;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [4:0]         slot;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] vel_z;
    logic [14:0]        radius;
    logic [15:0]        potency;
    logic [7:0]         generation;
    logic [15:0]        delta_t;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [4:0]         slot_out;
    logic signed [15:0] out_pos_x;
    logic signed [15:0] out_pos_y;
    logic signed [15:0] out_pos_z;
    logic signed [15:0] out_vel_x;
    logic signed [15:0] out_vel_y;
    logic signed [15:0] out_vel_z;
    logic [15:0]        out_potency;
    logic               use_particle;
    logic [5:0]         live_count;
    logic               last;
  } rsp_t;

  typedef struct packed {
    logic [2:0][15:0] pos;
    logic [2:0][15:0] vel;
    logic [14:0]      radius;
    logic [15:0]      potency;
    logic             flag;
  } entry_t;

  typedef struct packed {
    logic [5:0]  mode_flags;
    logic [47:0] gravity;
    logic [47:0] box_min;
    logic [47:0] box_max;
  } cfg_t;

  function automatic logic [15:0] sat18(input logic signed [17:0] v);
    logic [15:0] r;
    if (v > 18'sd32767) r = 16'h7fff;
    else if (v < -18'sd32768) r = 16'h8000;
    else r = v[15:0];
    return r;
  endfunction

  // a * dt with dt in unsigned q4.12, rounded half up and saturated to 16 bits
  function automatic logic [15:0] scale_dt(input logic [15:0] a, input logic [15:0] dt);
    logic signed [33:0] y;
    logic signed [33:0] q;
    logic [15:0] r;
    y = $signed({{18{a[15]}}, a}) * $signed({18'd0, dt}) + 34'sd2048;
    q = y >>> 12;
    if (q > 34'sd32767) r = 16'h7fff;
    else if (q < -34'sd32768) r = 16'h8000;
    else r = q[15:0];
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/pte_mem.sv
// entry store: one write port, one registered read port
`default_nettype none
module pte_mem (
  input  wire logic                              clk,
  input  wire logic                              we,
  input  wire logic [pte_pkg::SlotBits-1:0]      waddr,
  input  wire pte_pkg::entry_t                   wdata,
  input  wire logic [pte_pkg::SlotBits-1:0]      raddr,
  output pte_pkg::entry_t                        rdata
);

  pte_pkg::entry_t mem [pte_pkg::MaxEntries];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/pte_step.sv
// three stage euler step: gravity, position update, box collision
`default_nettype none
module pte_step (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire pte_pkg::entry_t ent,
  input  wire logic [15:0]     dt,
  input  wire pte_pkg::cfg_t   cfg,
  output pte_pkg::entry_t      res,
  output logic                 drop,
  output logic                 done
);

  pte_pkg::entry_t e1, e2, e1_next, e2_next, e3_next;
  logic v1, v2;
  logic hit;
  logic [1:0] mode;

  assign mode = cfg.mode_flags[5:4];

  always_comb begin
    logic [15:0] g;
    e1_next = ent;
    for (int a = 0; a < 3; a++) begin
      g = pte_pkg::scale_dt(cfg.gravity[16*a +: 16], dt);
      if (cfg.mode_flags[0]) begin
        e1_next.vel[a] = pte_pkg::sat18($signed({{2{ent.vel[a][15]}}, ent.vel[a]})
          + $signed({{2{g[15]}}, g}));
      end
    end
  end

  always_comb begin
    logic [15:0] d;
    e2_next = e1;
    for (int a = 0; a < 3; a++) begin
      d = pte_pkg::scale_dt(e1.vel[a], dt);
      e2_next.pos[a] = pte_pkg::sat18($signed({{2{e1.pos[a][15]}}, e1.pos[a]})
        + $signed({{2{d[15]}}, d}));
    end
  end

  always_comb begin
    logic signed [17:0] p, r, mn, mx, v;
    e3_next = e2;
    hit = 1'b0;
    for (int a = 0; a < 3; a++) begin
      p = $signed({{2{e2.pos[a][15]}}, e2.pos[a]});
      v = $signed({{2{e2.vel[a][15]}}, e2.vel[a]});
      r = $signed({3'd0, e2.radius});
      mn = $signed({{2{cfg.box_min[16*a+15]}}, cfg.box_min[16*a +: 16]});
      mx = $signed({{2{cfg.box_max[16*a+15]}}, cfg.box_max[16*a +: 16]});
      if (cfg.mode_flags[1]) begin
        if (p - r < mn) begin
          e3_next.pos[a] = pte_pkg::sat18(mn + r);
          if (mode == pte_pkg::BndBounce && v < 0) begin
            e3_next.vel[a] = pte_pkg::sat18(-v);
          end
          hit = 1'b1;
        end else if (p + r > mx) begin
          e3_next.pos[a] = pte_pkg::sat18(mx - r);
          if (mode == pte_pkg::BndBounce && v > 0) begin
            e3_next.vel[a] = pte_pkg::sat18(-v);
          end
          hit = 1'b1;
        end
      end
    end
    if (hit && mode == pte_pkg::BndDelete) begin
      e3_next.potency = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      done <= 1'b0;
    end else begin
      v1 <= start;
      v2 <= v1;
      done <= v2;
    end
    e1 <= e1_next;
    e2 <= e2_next;
    res <= e3_next;
    drop <= cfg.mode_flags[2] && (e3_next.potency == 16'd0);
  end

endmodule
`default_nettype wire

### rtl/particle_table_euler_step_unit.sv
// top level: particle table with launch, remove, read and euler tick
// channels: req (valid/ready) carries one request, rsp (valid/ready) returns
// results, cfg (valid/ready, index and data) writes the four registers and is
// always ready. requests are taken one at a time: req_ready is high only
// while the block is idle with no result pending.
// launch: result valid in the cycle after the request is taken, table full too.
// remove and read: the result is registered from the memory read in S_RD;
// an empty slot gets its result in the cycle after the request.
// tick: a first pass walks all 32 slots and steps each live one (memory
// read, gravity, position, collision and write back); a second pass reads
// the slots live at the start of the tick again and returns one result each
// (scan, memory read, output), waiting for the receiver to take each one.
// rate is set by the single read port of the entry memory and the three
// stage step unit that handles one entry at a time.
// reset clears the live bits, the count and the registers; entry memory is
// not cleared and needs no clearing pass.
// when the receiver stalls the result register holds and no new work starts.
`default_nettype none
module particle_table_euler_step_unit (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire pte_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output pte_pkg::rsp_t      rsp,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [47:0]   cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_P1_SCAN, S_P1_WAIT, S_P1_STEP, S_P2_SCAN, S_P2_WAIT, S_OUT
  } state_t;

  state_t state;
  pte_pkg::cfg_t cfg;
  logic [31:0] live, tmask, dmask;
  logic [5:0] count;
  logic [4:0] idx, slot_q, free_slot;
  logic [15:0] dt;
  logic in_p2;
  logic full;

  logic mem_we;
  logic [4:0] mem_waddr, mem_raddr;
  pte_pkg::entry_t mem_wdata, mem_rdata, launch_ent, step_res;
  logic step_drop, step_done;
  logic acc;

  assign cfg_ready = 1'b1;
  assign req_ready = (state == S_IDLE);
  assign acc = req_valid && req_ready;
  assign full = &live;

  always_comb begin
    free_slot = 5'd0;
    for (int i = 31; i >= 0; i--) begin
      if (!live[i]) free_slot = 5'(i);
    end
  end

  always_comb begin
    launch_ent.pos = {req.pos_z, req.pos_y, req.pos_x};
    launch_ent.vel = {req.vel_z, req.vel_y, req.vel_x};
    launch_ent.radius = req.radius;
    launch_ent.potency = req.potency;
    launch_ent.flag = cfg.mode_flags[3] && (req.generation >= 8'd2);
  end

  always_comb begin
    mem_we = 1'b0;
    mem_waddr = idx;
    mem_wdata = step_res;
    mem_raddr = idx;
    if (acc && req.opcode == pte_pkg::OP_LAUNCH && !full) begin
      mem_we = 1'b1;
      mem_waddr = free_slot;
      mem_wdata = launch_ent;
    end else if (state == S_P1_STEP && step_done) begin
      mem_we = 1'b1;
    end
    if (state == S_IDLE) mem_raddr = req.slot;
  end

  pte_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  pte_step u_step (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_P1_WAIT),
    .ent   (mem_rdata),
    .dt    (dt),
    .cfg   (cfg),
    .res   (step_res),
    .drop  (step_drop),
    .done  (step_done)
  );

  function automatic pte_pkg::rsp_t fill(input logic [1:0] st, input logic [4:0] s,
                                         input pte_pkg::entry_t e, input logic have,
                                         input logic [5:0] n, input logic lst);
    pte_pkg::rsp_t r;
    r = '0;
    r.status = st;
    r.slot_out = s;
    if (have) begin
      r.out_pos_x = e.pos[0];
      r.out_pos_y = e.pos[1];
      r.out_pos_z = e.pos[2];
      r.out_vel_x = e.vel[0];
      r.out_vel_y = e.vel[1];
      r.out_vel_z = e.vel[2];
      r.out_potency = e.potency;
      r.use_particle = e.flag;
    end
    r.live_count = n;
    r.last = lst;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cfg <= '0;
      live <= '0;
      count <= '0;
      rsp_valid <= 1'b0;
      in_p2 <= 1'b0;
      idx <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          pte_pkg::REG_MODE:    cfg.mode_flags <= cfg_data[5:0];
          pte_pkg::REG_GRAVITY: cfg.gravity <= cfg_data;
          pte_pkg::REG_BOX_MIN: cfg.box_min <= cfg_data;
          pte_pkg::REG_BOX_MAX: cfg.box_max <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (acc) begin
            slot_q <= req.slot;
            dt <= req.delta_t;
            case (req.opcode)
              pte_pkg::OP_LAUNCH: begin
                if (full) begin
                  rsp <= fill(pte_pkg::ST_FULL, 5'd0, launch_ent, 1'b0, count, 1'b1);
                end else begin
                  live[free_slot] <= 1'b1;
                  count <= count + 6'd1;
                  rsp <= fill(pte_pkg::ST_OK, free_slot, launch_ent, 1'b1,
                              count + 6'd1, 1'b1);
                end
                rsp_valid <= 1'b1;
                state <= S_OUT;
              end
              pte_pkg::OP_TICK: begin
                tmask <= live;
                dmask <= '0;
                idx <= '0;
                in_p2 <= 1'b0;
                if (live == '0) begin
                  rsp <= fill(pte_pkg::ST_EMPTY, 5'd0, launch_ent, 1'b0, count, 1'b1);
                  rsp_valid <= 1'b1;
                  state <= S_OUT;
                end else begin
                  state <= S_P1_SCAN;
                end
              end
              default: begin
                if (!live[req.slot]) begin
                  rsp <= fill(pte_pkg::ST_EMPTY, req.slot, launch_ent, 1'b0, count, 1'b1);
                  rsp_valid <= 1'b1;
                  state <= S_OUT;
                end else begin
                  if (req.opcode == pte_pkg::OP_REMOVE) begin
                    live[req.slot] <= 1'b0;
                    count <= count - 6'd1;
                  end
                  state <= S_RD;
                end
              end
            endcase
          end
        end
        S_RD: begin
          rsp <= fill(pte_pkg::ST_OK, slot_q, mem_rdata, 1'b1, count, 1'b1);
          rsp_valid <= 1'b1;
          state <= S_OUT;
        end
        S_P1_SCAN: begin
          if (tmask[idx]) begin
            state <= S_P1_WAIT;
          end else if (idx == 5'd31) begin
            idx <= '0;
            state <= S_P2_SCAN;
          end else begin
            idx <= idx + 5'd1;
          end
        end
        S_P1_WAIT: state <= S_P1_STEP;
        S_P1_STEP: begin
          if (step_done) begin
            if (step_drop) begin
              live[idx] <= 1'b0;
              dmask[idx] <= 1'b1;
              count <= count - 6'd1;
            end
            if (idx == 5'd31) begin
              idx <= '0;
              state <= S_P2_SCAN;
            end else begin
              idx <= idx + 5'd1;
              state <= S_P1_SCAN;
            end
          end
        end
        S_P2_SCAN: begin
          in_p2 <= 1'b1;
          if (tmask[idx]) state <= S_P2_WAIT;
          else idx <= idx + 5'd1;
        end
        S_P2_WAIT: begin
          rsp <= fill(dmask[idx] ? pte_pkg::ST_REMOVED : pte_pkg::ST_OK, idx, mem_rdata,
                      1'b1, count, (tmask >> idx) == 32'd1);
          rsp_valid <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: begin
          if (rsp_ready) begin
            rsp_valid <= 1'b0;
            if (in_p2 && !rsp.last) begin
              idx <= idx + 5'd1;
              state <= S_P2_SCAN;
            end else begin
              in_p2 <= 1'b0;
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### rtl/pte_checker.sv
// port level checker for the particle table, bound to the top level
`default_nettype none
module pte_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          req_ready,
  input wire logic          rsp_valid,
  input wire logic          rsp_ready,
  input wire pte_pkg::rsp_t rsp
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result dropped or changed while stalled");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == pte_pkg::ST_FULL |-> rsp.live_count == 6'd32)
    else $error("table full with fewer than 32 live entries");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.live_count <= 6'd32)
    else $error("live count out of range");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == pte_pkg::ST_EMPTY |-> rsp.out_potency == 16'd0 &&
      !rsp.use_particle && rsp.last)
    else $error("empty result carries data");

  a_no_req_while_busy: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !req_ready)
    else $error("request taken while result pending");

endmodule

bind particle_table_euler_step_unit pte_checker u_pte_checker (
  .clk       (clk),
  .rst       (rst),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);
`default_nettype wire

### sim/tb_particle_table_euler_step_unit.sv
// testbench for the particle table euler step unit: directed table plus random requests
`timescale 1ns / 100ps
`default_nettype none
module tb_particle_table_euler_step_unit;

  localparam int WatchdogLimit = 20000;

  typedef struct {
    bit                 is_cfg;
    pte_pkg::cfg_reg_t  idx;
    logic [47:0]        data;
    pte_pkg::req_t      r;
    bit                 typed;
    pte_pkg::rsp_t      e;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  pte_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  pte_pkg::rsp_t rsp;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [47:0] cfg_data = '0;

  particle_table_euler_step_unit dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // table shadow
  logic signed [15:0] pos_sh[pte_pkg::MaxEntries][3];
  logic signed [15:0] vel_sh[pte_pkg::MaxEntries][3];
  logic [14:0]        rad_sh[pte_pkg::MaxEntries];
  logic [15:0]        pot_sh[pte_pkg::MaxEntries];
  bit                 flag_sh[pte_pkg::MaxEntries];
  bit [31:0]          live_sh;
  logic [5:0]         mode_sh;
  logic [47:0]        grav_sh, bmin_sh, bmax_sh;

  pte_pkg::rsp_t expected_q[$];
  int errors = 0;
  int send_idle = 0;
  int recv_stall = 0;
  int quiet_cycles = 0;

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0h want %0h (t=%0t)", what, got, want, $realtime);
    errors++;
  endtask

  function automatic longint sat16(input longint v);
    return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
  endfunction

  function automatic longint dt_scaled(input longint a, input longint dt);
    longint y;
    y = a * dt + 2048;
    return sat16(y >>> 12);
  endfunction

  function automatic longint axis_of(input logic [47:0] v, input int a);
    return longint'($signed(v[16*a +: 16]));
  endfunction

  function automatic pte_pkg::rsp_t entry_rsp(input pte_pkg::status_t st, input int s,
                                              input bit have);
    pte_pkg::rsp_t o;
    o = '0;
    o.status = st;
    o.slot_out = s[4:0];
    if (have) begin
      o.out_pos_x = pos_sh[s][0]; o.out_pos_y = pos_sh[s][1]; o.out_pos_z = pos_sh[s][2];
      o.out_vel_x = vel_sh[s][0]; o.out_vel_y = vel_sh[s][1]; o.out_vel_z = vel_sh[s][2];
      o.out_potency = pot_sh[s];
      o.use_particle = flag_sh[s];
    end
    o.live_count = 6'($countones(live_sh));
    o.last = 1'b1;
    return o;
  endfunction

  // one euler step of an entry, returns 1 when the entry is dropped
  function automatic bit euler_step(input int s, input logic [15:0] dt);
    bit hit;
    longint p, v, r, mn, mx;
    hit = 0;
    for (int a = 0; a < 3; a++) begin
      p = pos_sh[s][a];
      v = vel_sh[s][a];
      if (mode_sh[0]) v = sat16(v + dt_scaled(axis_of(grav_sh, a), dt));
      p = sat16(p + dt_scaled(v, dt));
      if (mode_sh[1]) begin
        r = rad_sh[s];
        mn = axis_of(bmin_sh, a);
        mx = axis_of(bmax_sh, a);
        if (p - r < mn) begin
          p = sat16(mn + r);
          if (mode_sh[5:4] == pte_pkg::BndBounce && v < 0) v = sat16(-v);
          hit = 1;
        end else if (p + r > mx) begin
          p = sat16(mx - r);
          if (mode_sh[5:4] == pte_pkg::BndBounce && v > 0) v = sat16(-v);
          hit = 1;
        end
      end
      pos_sh[s][a] = 16'(p);
      vel_sh[s][a] = 16'(v);
    end
    if (hit && mode_sh[5:4] == pte_pkg::BndDelete) pot_sh[s] = '0;
    return mode_sh[2] && pot_sh[s] == 0;
  endfunction

  task automatic predict_request(input pte_pkg::req_t r);
    int i, n;
    bit dropped[pte_pkg::MaxEntries];
    bit [31:0] start;
    pte_pkg::rsp_t o;
    case (pte_pkg::opcode_t'(r.opcode))
      pte_pkg::OP_LAUNCH: begin
        i = 0;
        while (i < pte_pkg::MaxEntries && live_sh[i]) i++;
        if (i == pte_pkg::MaxEntries) begin
          expected_q.push_back(entry_rsp(pte_pkg::ST_FULL, 0, 0));
        end else begin
          pos_sh[i][0] = r.pos_x; pos_sh[i][1] = r.pos_y; pos_sh[i][2] = r.pos_z;
          vel_sh[i][0] = r.vel_x; vel_sh[i][1] = r.vel_y; vel_sh[i][2] = r.vel_z;
          rad_sh[i] = r.radius;
          pot_sh[i] = r.potency;
          flag_sh[i] = mode_sh[3] && r.generation >= 2;
          live_sh[i] = 1'b1;
          expected_q.push_back(entry_rsp(pte_pkg::ST_OK, i, 1));
        end
      end
      pte_pkg::OP_REMOVE, pte_pkg::OP_READ: begin
        if (!live_sh[r.slot]) begin
          expected_q.push_back(entry_rsp(pte_pkg::ST_EMPTY, r.slot, 0));
        end else begin
          if (r.opcode == pte_pkg::OP_REMOVE) live_sh[r.slot] = 1'b0;
          expected_q.push_back(entry_rsp(pte_pkg::ST_OK, r.slot, 1));
        end
      end
      default: begin
        start = live_sh;
        if (start == 0) begin
          expected_q.push_back(entry_rsp(pte_pkg::ST_EMPTY, 0, 0));
        end else begin
          for (i = 0; i < pte_pkg::MaxEntries; i++) begin
            dropped[i] = 0;
            if (start[i]) begin
              dropped[i] = euler_step(i, r.delta_t);
              if (dropped[i]) live_sh[i] = 1'b0;
            end
          end
          n = $countones(start);
          for (i = 0; i < pte_pkg::MaxEntries; i++) begin
            if (start[i]) begin
              o = entry_rsp(dropped[i] ? pte_pkg::ST_REMOVED : pte_pkg::ST_OK, i, 1);
              n--;
              o.last = (n == 0);
              expected_q.push_back(o);
            end
          end
        end
      end
    endcase
  endtask

  // result checker
  always @(posedge clk) begin
    pte_pkg::rsp_t e;
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_q.size() == 0) begin
        report("unexpected result, status", rsp.status, 0);
      end else begin
        e = expected_q.pop_front();
        if (rsp.status !== e.status) report("status", rsp.status, e.status);
        if (rsp.slot_out !== e.slot_out) report("slot_out", rsp.slot_out, e.slot_out);
        if (rsp.out_pos_x !== e.out_pos_x) report("out_pos_x", rsp.out_pos_x, e.out_pos_x);
        if (rsp.out_pos_y !== e.out_pos_y) report("out_pos_y", rsp.out_pos_y, e.out_pos_y);
        if (rsp.out_pos_z !== e.out_pos_z) report("out_pos_z", rsp.out_pos_z, e.out_pos_z);
        if (rsp.out_vel_x !== e.out_vel_x) report("out_vel_x", rsp.out_vel_x, e.out_vel_x);
        if (rsp.out_vel_y !== e.out_vel_y) report("out_vel_y", rsp.out_vel_y, e.out_vel_y);
        if (rsp.out_vel_z !== e.out_vel_z) report("out_vel_z", rsp.out_vel_z, e.out_vel_z);
        if (rsp.out_potency !== e.out_potency)
          report("out_potency", rsp.out_potency, e.out_potency);
        if (rsp.use_particle !== e.use_particle)
          report("use_particle", rsp.use_particle, e.use_particle);
        if (rsp.live_count !== e.live_count)
          report("live_count", rsp.live_count, e.live_count);
        if (rsp.last !== e.last) report("last", rsp.last, e.last);
      end
    end
  end

  always @(posedge clk) rsp_ready <= ($urandom_range(99) >= recv_stall);

  always @(posedge clk) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_request(input pte_pkg::req_t r, input bit typed,
                              input pte_pkg::rsp_t e);
    while ($urandom_range(99) < send_idle) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    if (typed) begin
      predict_request(r);
      void'(expected_q.pop_back());
      expected_q.push_back(e);
    end else begin
      predict_request(r);
    end
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input pte_pkg::cfg_reg_t idx, input logic [47:0] d);
    cfg_index <= idx;
    cfg_data <= d;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      pte_pkg::REG_MODE:    mode_sh = d[5:0];
      pte_pkg::REG_GRAVITY: grav_sh = d;
      pte_pkg::REG_BOX_MIN: bmin_sh = d;
      default:              bmax_sh = d;
    endcase
    @(posedge clk);
  endtask

  function automatic pte_pkg::req_t make_req(input pte_pkg::opcode_t op, input int slot,
                                    input int px, input int py, input int pz,
                                    input int vx, input int vy, input int vz,
                                    input int rad, input int pot, input int gen, input int dt);
    pte_pkg::req_t r;
    r.opcode = op; r.slot = 5'(slot);
    r.pos_x = 16'(px); r.pos_y = 16'(py); r.pos_z = 16'(pz);
    r.vel_x = 16'(vx); r.vel_y = 16'(vy); r.vel_z = 16'(vz);
    r.radius = 15'(rad); r.potency = 16'(pot); r.generation = 8'(gen); r.delta_t = 16'(dt);
    return r;
  endfunction

  function automatic row_t req_row(input pte_pkg::req_t r);
    row_t w;
    w.is_cfg = 0;
    w.idx = pte_pkg::REG_MODE;
    w.data = '0;
    w.typed = 0;
    w.e = '0;
    w.r = r;
    return w;
  endfunction

  function automatic row_t cfg_row(input pte_pkg::cfg_reg_t idx, input logic [47:0] d);
    row_t w;
    w.r = '0;
    w.typed = 0;
    w.e = '0;
    w.is_cfg = 1; w.idx = idx; w.data = d;
    return w;
  endfunction

  function automatic row_t empty_row(input pte_pkg::req_t r, input int slot);
    row_t w;
    w = req_row(r);
    w.typed = 1;
    w.e = '0;
    w.e.status = pte_pkg::ST_EMPTY;
    w.e.slot_out = 5'(slot);
    w.e.last = 1'b1;
    return w;
  endfunction

  function automatic pte_pkg::req_t random_req(input int launch_pct);
    pte_pkg::req_t r;
    int live_idx[$];
    int pick;
    r = ($bits(pte_pkg::req_t))'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                  $urandom});
    pick = $urandom_range(99);
    if (pick < launch_pct) r.opcode = pte_pkg::OP_LAUNCH;
    else if (pick < launch_pct + (100 - launch_pct) / 3) r.opcode = pte_pkg::OP_TICK;
    else r.opcode = $urandom_range(1) ? pte_pkg::OP_REMOVE : pte_pkg::OP_READ;
    for (int i = 0; i < pte_pkg::MaxEntries; i++) if (live_sh[i]) live_idx.push_back(i);
    if (live_idx.size() != 0 && $urandom_range(99) < 80)
      r.slot = 5'(live_idx[$urandom_range(live_idx.size() - 1)]);
    if ($urandom_range(99) < 80) r.radius = 15'($urandom_range(80));
    if ($urandom_range(99) < 75) r.delta_t = 16'($urandom_range(4096));
    if ($urandom_range(99) < 60) begin
      r.pos_x = 16'($signed($urandom_range(4000)) - 2000);
      r.pos_y = 16'($signed($urandom_range(4000)) - 2000);
      r.pos_z = 16'($signed($urandom_range(4000)) - 2000);
    end
    if ($urandom_range(99) < 20) r.potency = '0;
    return r;
  endfunction

  function automatic logic [47:0] random_box(input bit upper);
    logic [47:0] b;
    for (int a = 0; a < 3; a++)
      b[16*a +: 16] = upper ? 16'($urandom_range(3000)) : 16'(-$signed($urandom_range(3000)));
    return b;
  endfunction

  initial begin
    row_t rows[$];
    int phase_idle[4] = '{0, 61, 0, 10};
    int phase_stall[4] = '{0, 0, 61, 10};
    pte_pkg::rsp_t none;
    none = '0;
    live_sh = '0;
    mode_sh = '0; grav_sh = '0; bmin_sh = '0; bmax_sh = '0;

    // directed table
    rows.push_back(empty_row(make_req(pte_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1), 0));
    rows.push_back(empty_row(make_req(pte_pkg::OP_READ, 5, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 5));
    rows.push_back(empty_row(make_req(pte_pkg::OP_REMOVE, 31, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                             31));
    rows.push_back(cfg_row(pte_pkg::REG_MODE, 48'(1 | 2 | 8 | (1 << 4))));
    rows.push_back(cfg_row(pte_pkg::REG_GRAVITY, {16'h7fff, 16'h0000, 16'hfff0}));
    rows.push_back(cfg_row(pte_pkg::REG_BOX_MIN, {3{16'hf9c0}}));
    rows.push_back(cfg_row(pte_pkg::REG_BOX_MAX, {3{16'h0640}}));
    rows.push_back(req_row(make_req(pte_pkg::OP_LAUNCH, 0, 32767, -32768, 0, -32768, 32767, 0,
                                    32767, 65535, 255, 0)));
    rows.push_back(req_row(make_req(pte_pkg::OP_LAUNCH, 0, -1000, 0, 500, -32768, 0, 0, 0, 0,
                                    2, 0)));
    rows.push_back(req_row(make_req(pte_pkg::OP_LAUNCH, 0, 10, 20, 30, 16, -16, 4, 8, 256,
                                    1, 0)));
    rows.push_back(req_row(make_req(pte_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 65535)));
    rows.push_back(req_row(make_req(pte_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0)));
    rows.push_back(req_row(make_req(pte_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0)));
    rows.push_back(req_row(make_req(pte_pkg::OP_REMOVE, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0)));
    rows.push_back(req_row(make_req(pte_pkg::OP_READ, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0)));
    rows.push_back(req_row(make_req(pte_pkg::OP_LAUNCH, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0)));
    rows.push_back(cfg_row(pte_pkg::REG_MODE, 48'(2 | 4 | (2 << 4))));
    rows.push_back(req_row(make_req(pte_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 4096)));
    rows.push_back(req_row(make_req(pte_pkg::OP_LAUNCH, 0, 5000, 0, 0, 800, 0, 0, 4, 300,
                                    3, 0)));
    rows.push_back(cfg_row(pte_pkg::REG_MODE, 48'(2 | (3 << 4))));
    rows.push_back(req_row(make_req(pte_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 2048)));
    rows.push_back(cfg_row(pte_pkg::REG_MODE, 48'(0)));
    rows.push_back(req_row(make_req(pte_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 4096)));
    rows.push_back(req_row(make_req(pte_pkg::OP_REMOVE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0)));

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[k]) begin
      if (rows[k].is_cfg) begin
        drain();
        write_reg(rows[k].idx, rows[k].data);
      end else begin
        send_request(rows[k].r, rows[k].typed, rows[k].typed ? rows[k].e : none);
      end
    end
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle = phase_idle[ph];
      recv_stall = phase_stall[ph];
      if (ph == 3) begin
        write_reg(pte_pkg::REG_MODE, 48'd63);
        write_reg(pte_pkg::REG_GRAVITY, 48'hffff_ffff_ffff);
        write_reg(pte_pkg::REG_BOX_MIN, {3{16'h8000}});
        write_reg(pte_pkg::REG_BOX_MAX, {3{16'h7fff}});
      end else begin
        write_reg(pte_pkg::REG_MODE, 48'($urandom_range(63)));
        write_reg(pte_pkg::REG_GRAVITY, {16'($signed($urandom_range(64)) - 32),
                                         16'($signed($urandom_range(64)) - 32),
                                         16'($signed($urandom_range(64)) - 32)});
        write_reg(pte_pkg::REG_BOX_MIN, random_box(0));
        write_reg(pte_pkg::REG_BOX_MAX, random_box(1));
      end
      // fill the table past full once, then mixed traffic
      if (ph == 0) repeat (34) send_request(random_req(100), 0, none);
      repeat (ph == 0 ? 10 : 23) send_request(random_req(40), 0, none);
      drain();
    end

    drain();
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire
